FILE: rtl/knis_pkg.sv
package knis_pkg;

	localparam int MAX_K_DEF     = 16;
	localparam int ID_BITS_DEF   = 16;
	localparam int DIST_BITS_DEF = 32;

	localparam int K_BITS      = 5;
	localparam int RANK_BITS   = 4;
	localparam int COUNT_BITS  = 5;
	localparam int K_RESET     = 16;

	// per-cycle command shared by every cell of the chain
	typedef struct packed {
		logic insert;   // a candidate word is offered to the chain
		logic drain;    // shift the chain one place toward rank 0
	} cell_ctrl_t;

endpackage

FILE: rtl/knis_cand_if.sv
interface knis_cand_if #(
	parameter int ID_BITS   = knis_pkg::ID_BITS_DEF,
	parameter int DIST_BITS = knis_pkg::DIST_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic                 has_candidate;
	logic [DIST_BITS-1:0] distance;
	logic [ID_BITS-1:0]   candidate_id;
	logic                 end_of_query;

	modport source (
		output valid, has_candidate, distance, candidate_id, end_of_query,
		input  ready
	);
	modport sink (
		input  valid, has_candidate, distance, candidate_id, end_of_query,
		output ready
	);
endinterface

FILE: rtl/knis_res_if.sv
interface knis_res_if #(
	parameter int ID_BITS   = knis_pkg::ID_BITS_DEF,
	parameter int DIST_BITS = knis_pkg::DIST_BITS_DEF
);
	logic                             valid;
	logic                             ready;
	logic                             result_valid;
	logic [knis_pkg::RANK_BITS-1:0]   rank;
	logic [ID_BITS-1:0]               nearest_id;
	logic [DIST_BITS-1:0]             nearest_distance;
	logic [knis_pkg::COUNT_BITS-1:0]  kept_count;
	logic                             last_result;

	modport source (
		output valid, result_valid, rank, nearest_id, nearest_distance, kept_count,
		       last_result,
		input  ready
	);
	modport sink (
		input  valid, result_valid, rank, nearest_id, nearest_distance, kept_count,
		       last_result,
		output ready
	);
endinterface

FILE: rtl/knis_cell.sv
module knis_cell #(
	parameter int ID_BITS   = knis_pkg::ID_BITS_DEF,
	parameter int DIST_BITS = knis_pkg::DIST_BITS_DEF
) (
	input  logic                 clk,
	input  knis_pkg::cell_ctrl_t ctrl,
	input  logic                 in_range,
	input  logic                 occupied,
	input  logic [DIST_BITS-1:0] new_dist,
	input  logic [ID_BITS-1:0]   new_id,
	input  logic                 prev_take,
	input  logic [DIST_BITS-1:0] prev_dist,
	input  logic [ID_BITS-1:0]   prev_id,
	input  logic [DIST_BITS-1:0] next_dist,
	input  logic [ID_BITS-1:0]   next_id,
	output logic                 take,
	output logic [DIST_BITS-1:0] cur_dist,
	output logic [ID_BITS-1:0]   id
);
	logic [DIST_BITS-1:0] dist_q;
	logic [ID_BITS-1:0]   id_q;
	logic                 less;

	// an empty cell acts as infinity; strict compare keeps earlier arrivals first on ties
	assign less     = !occupied || (new_dist < dist_q);
	assign take     = ctrl.insert && in_range && less;
	assign cur_dist = dist_q;
	assign id       = id_q;

	always_ff @(posedge clk) begin
		if (ctrl.drain) begin
			dist_q <= next_dist;
			id_q   <= next_id;
		end else if (take) begin
			// neighbor above also moves down: take its entry, else the new one lands here
			if (prev_take) begin
				dist_q <= prev_dist;
				id_q   <= prev_id;
			end else begin
				dist_q <= new_dist;
				id_q   <= new_id;
			end
		end
	end

endmodule

FILE: rtl/k_nearest_insertion_select.sv
// k-nearest selection by sorted insertion.
// cand: one word per candidate (distance, candidate_id), has_candidate = 0 for a
//   bare end marker, end_of_query = 1 on the last word of a query. While the block
//   collects, a word is taken every cycle; a row of MAX_K cells compares the new
//   distance against every held entry in parallel and shifts the tail down by one.
// res: after the end word, one word per kept entry in ascending distance order,
//   then the next query may start. A query whose list is empty (or k_in_use = 0)
//   gives one word with result_valid = 0 and last_result = 1.
// After the end word is taken the block enters its emit state and loads the first
//   result word into the output register; one word leaves per cycle while res.ready
//   is high, and cand stays blocked until the last word of the query is loaded.
// The result word sits in an output register; while res is stalled the chain holds
//   and cand stays blocked until the last word of the query has been loaded.
// cfg_wr_en / cfg_wr_data write k_in_use (values above MAX_K act as MAX_K); write it
//   only between queries. Reset clears the fill count and sets k_in_use to 16; the
//   cell contents need no clearing.
module k_nearest_insertion_select #(
	parameter int MAX_K     = knis_pkg::MAX_K_DEF,
	parameter int ID_BITS   = knis_pkg::ID_BITS_DEF,
	parameter int DIST_BITS = knis_pkg::DIST_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	knis_cand_if.sink                     cand,
	knis_res_if.source                    res,
	input  logic                          cfg_wr_en,
	input  logic [knis_pkg::K_BITS-1:0]   cfg_wr_data
);
	localparam int CW = $clog2(MAX_K + 1);
	localparam int LW = (CW > knis_pkg::K_BITS) ? CW : knis_pkg::K_BITS;

	typedef enum logic {ST_COLLECT, ST_EMIT} state_t;

	state_t                      state_q;
	logic [knis_pkg::K_BITS-1:0] k_q;
	logic [CW-1:0]               cnt_q;
	logic [CW-1:0]               n_q;
	logic [CW-1:0]               rank_q;

	logic                        ovalid_q;
	logic                        oresult_valid_q;
	logic [knis_pkg::RANK_BITS-1:0]  orank_q;
	logic [ID_BITS-1:0]          oid_q;
	logic [DIST_BITS-1:0]        odist_q;
	logic [knis_pkg::COUNT_BITS-1:0] ocount_q;
	logic                        olast_q;

	logic [CW-1:0]               lim;
	logic [CW-1:0]               cnt_eff;
	logic [CW-1:0]               cnt_next;
	logic                        accept;
	logic                        load_out;
	knis_pkg::cell_ctrl_t        ctrl;

	logic                        take [MAX_K];
	logic [DIST_BITS-1:0]        cdist [MAX_K];
	logic [ID_BITS-1:0]          cid [MAX_K];

	assign lim = (LW'(k_q) > LW'(MAX_K)) ? CW'(MAX_K) : CW'(k_q);
	// entries beyond a lowered k are dropped
	assign cnt_eff  = (cnt_q > lim) ? lim : cnt_q;
	assign cnt_next = (cand.has_candidate && (cnt_eff < lim)) ? cnt_eff + CW'(1) : cnt_eff;

	assign cand.ready = (state_q == ST_COLLECT);
	assign accept     = cand.valid && cand.ready;
	assign load_out   = (state_q == ST_EMIT) && (!ovalid_q || res.ready);

	assign ctrl.insert = accept && cand.has_candidate;
	assign ctrl.drain  = load_out && (n_q != '0);

	for (genvar i = 0; i < MAX_K; i++) begin : g_cell
		logic                 prev_take;
		logic [DIST_BITS-1:0] prev_dist;
		logic [ID_BITS-1:0]   prev_id;
		logic [DIST_BITS-1:0] next_dist;
		logic [ID_BITS-1:0]   next_id;

		if (i == 0) begin : g_head
			assign prev_take = 1'b0;
			assign prev_dist = '0;
			assign prev_id   = '0;
		end else begin : g_body
			assign prev_take = take[i-1];
			assign prev_dist = cdist[i-1];
			assign prev_id   = cid[i-1];
		end

		if (i == MAX_K - 1) begin : g_tail
			assign next_dist = '0;
			assign next_id   = '0;
		end else begin : g_mid
			assign next_dist = cdist[i+1];
			assign next_id   = cid[i+1];
		end

		knis_cell #(
			.ID_BITS   (ID_BITS),
			.DIST_BITS (DIST_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.in_range  (CW'(i) < lim),
			.occupied  (CW'(i) < cnt_eff),
			.new_dist  (cand.distance),
			.new_id    (cand.candidate_id),
			.prev_take (prev_take),
			.prev_dist (prev_dist),
			.prev_id   (prev_id),
			.next_dist (next_dist),
			.next_id   (next_id),
			.take      (take[i]),
			.cur_dist  (cdist[i]),
			.id        (cid[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= knis_pkg::K_BITS'(knis_pkg::K_RESET);
		end else if (cfg_wr_en) begin
			k_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_COLLECT;
			cnt_q           <= '0;
			n_q             <= '0;
			rank_q          <= '0;
			ovalid_q        <= 1'b0;
			oresult_valid_q <= 1'b0;
			orank_q         <= '0;
			oid_q           <= '0;
			odist_q         <= '0;
			ocount_q        <= '0;
			olast_q         <= 1'b0;
		end else begin
			if (res.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_COLLECT: begin
					if (accept) begin
						if (cand.end_of_query) begin
							n_q     <= cnt_next;
							cnt_q   <= '0;
							rank_q  <= '0;
							state_q <= ST_EMIT;
						end else begin
							cnt_q <= cnt_next;
						end
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						ovalid_q <= 1'b1;
						orank_q  <= knis_pkg::RANK_BITS'(rank_q);
						ocount_q <= knis_pkg::COUNT_BITS'(n_q);
						if (n_q == '0) begin
							oresult_valid_q <= 1'b0;
							oid_q           <= '0;
							odist_q         <= '0;
							olast_q         <= 1'b1;
							state_q         <= ST_COLLECT;
						end else begin
							// rank 0 always sits in the head cell; the chain drains toward it
							oresult_valid_q <= 1'b1;
							oid_q           <= cid[0];
							odist_q         <= cdist[0];
							olast_q         <= (rank_q + CW'(1) == n_q);
							rank_q          <= rank_q + CW'(1);
							if (rank_q + CW'(1) == n_q) begin
								state_q <= ST_COLLECT;
							end
						end
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	assign res.valid            = ovalid_q;
	assign res.result_valid     = oresult_valid_q;
	assign res.rank             = orank_q;
	assign res.nearest_id       = oid_q;
	assign res.nearest_distance = odist_q;
	assign res.kept_count       = ocount_q;
	assign res.last_result      = olast_q;

endmodule

FILE: verif/tb_k_nearest_insertion_select.sv
`timescale 1ns / 1ps

module tb_k_nearest_insertion_select;

	localparam int KEEP_MAX = knis_pkg::MAX_K_DEF;
	localparam int ID_W     = knis_pkg::ID_BITS_DEF;
	localparam int DIST_W   = knis_pkg::DIST_BITS_DEF;

	typedef struct packed {
		logic              has_candidate;
		logic [DIST_W-1:0] distance;
		logic [ID_W-1:0]   candidate_id;
		logic              end_of_query;
	} cand_word_t;

	typedef struct packed {
		logic                              result_valid;
		logic [knis_pkg::RANK_BITS-1:0]    rank;
		logic [ID_W-1:0]                   nearest_id;
		logic [DIST_W-1:0]                 nearest_distance;
		logic [knis_pkg::COUNT_BITS-1:0]   kept_count;
		logic                              last_result;
	} answer_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [knis_pkg::K_BITS-1:0] cfg_wr_data;

	knis_cand_if cand_ch ();
	knis_res_if  res_ch ();

	k_nearest_insertion_select dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cand        (cand_ch),
		.res         (res_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// scoreboard copy of the selection state
	logic [DIST_W-1:0] held_dist [KEEP_MAX];
	logic [ID_W-1:0]   held_id   [KEEP_MAX];
	int                held_count;
	int                k_setting;

	cand_word_t pending_words [$];
	answer_t    expected_answers [$];
	cand_word_t next_word;

	logic cand_taken;
	bit   allow_idle;
	int   send_idle_pct;
	int   take_idle_pct;
	int   send_gap;
	int   take_gap;

	int words_queued;
	int words_taken;
	int answers_checked;
	int queries_closed;
	int random_items;
	int fail_count;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// move entry pos toward rank 0 while strictly nearer than the one above
	function automatic void bubble_up(int pos);
		logic [DIST_W-1:0] d;
		logic [ID_W-1:0]   i;
		while (pos > 0 && held_dist[pos] < held_dist[pos-1]) begin
			d = held_dist[pos];
			i = held_id[pos];
			held_dist[pos]   = held_dist[pos-1];
			held_id[pos]     = held_id[pos-1];
			held_dist[pos-1] = d;
			held_id[pos-1]   = i;
			pos--;
		end
	endfunction

	function automatic void absorb_word(cand_word_t w);
		int lim;
		answer_t a;
		lim = (k_setting > KEEP_MAX) ? KEEP_MAX : k_setting;
		// drop the worst entries when k was lowered mid-query
		if (held_count > lim)
			held_count = lim;
		if (w.has_candidate && lim > 0) begin
			if (held_count < lim) begin
				held_dist[held_count] = w.distance;
				held_id[held_count]   = w.candidate_id;
				held_count++;
				bubble_up(held_count - 1);
			end else if (w.distance < held_dist[held_count-1]) begin
				held_dist[held_count-1] = w.distance;
				held_id[held_count-1]   = w.candidate_id;
				bubble_up(held_count - 1);
			end
		end
		if (w.end_of_query) begin
			queries_closed++;
			if (held_count == 0) begin
				a = '0;
				a.last_result = 1'b1;
				expected_answers.push_back(a);
			end else begin
				for (int r = 0; r < held_count; r++) begin
					a.result_valid     = 1'b1;
					a.rank             = knis_pkg::RANK_BITS'(r);
					a.nearest_id       = held_id[r];
					a.nearest_distance = held_dist[r];
					a.kept_count       = knis_pkg::COUNT_BITS'(held_count);
					a.last_result      = (r == held_count - 1);
					expected_answers.push_back(a);
				end
			end
			held_count = 0;
		end
	endfunction

	function automatic void check_field(string name, logic [DIST_W-1:0] exp_v,
			logic [DIST_W-1:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			fail_count++;
		end
	endfunction

	function automatic logic [DIST_W-1:0] pick_distance();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 7);
			1: return 32'hFFFF_FFF8 | $urandom_range(0, 7);
			default: return $urandom();
		endcase
	endfunction

	// input side: track acceptance, predict; output side: check
	always @(posedge clk) begin : observe
		answer_t got, want;
		if (!arst_n) begin
			cand_taken <= 1'b0;
		end else begin
			cand_taken <= cand_ch.valid && (cand_ch.ready === 1'b1);
			if (cand_ch.valid && (cand_ch.ready === 1'b1)) begin
				absorb_word('{cand_ch.has_candidate, cand_ch.distance,
					cand_ch.candidate_id, cand_ch.end_of_query});
				words_taken++;
			end
			if ((res_ch.valid === 1'b1) && res_ch.ready) begin
				got = '{res_ch.result_valid, res_ch.rank, res_ch.nearest_id,
					res_ch.nearest_distance, res_ch.kept_count, res_ch.last_result};
				if (expected_answers.size() == 0) begin
					$error("result word with nothing expected: valid %0b rank %0d id %0h",
						got.result_valid, got.rank, got.nearest_id);
					fail_count++;
				end else begin
					want = expected_answers.pop_front();
					check_field("result_valid", DIST_W'(want.result_valid),
						DIST_W'(got.result_valid));
					check_field("rank", DIST_W'(want.rank), DIST_W'(got.rank));
					check_field("nearest_id", DIST_W'(want.nearest_id),
						DIST_W'(got.nearest_id));
					check_field("nearest_distance", want.nearest_distance,
						got.nearest_distance);
					check_field("kept_count", DIST_W'(want.kept_count),
						DIST_W'(got.kept_count));
					check_field("last_result", DIST_W'(want.last_result),
						DIST_W'(got.last_result));
					answers_checked++;
				end
			end
		end
	end

	always @(negedge clk) begin : cand_driver
		if (arst_n) begin
			if (cand_ch.valid && !cand_taken) begin
				// hold the word until it is taken
			end else if (send_gap > 0) begin
				cand_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (allow_idle && $urandom_range(0, 99) < send_idle_pct) begin
				cand_ch.valid <= 1'b0;
				send_gap <= $urandom_range(0, 2);
			end else if (pending_words.size() > 0) begin
				next_word = pending_words.pop_front();
				cand_ch.valid         <= 1'b1;
				cand_ch.has_candidate <= next_word.has_candidate;
				cand_ch.distance      <= next_word.distance;
				cand_ch.candidate_id  <= next_word.candidate_id;
				cand_ch.end_of_query  <= next_word.end_of_query;
			end else begin
				cand_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : res_stall
		if (take_gap > 0) begin
			res_ch.ready <= 1'b0;
			take_gap <= take_gap - 1;
		end else if (allow_idle && $urandom_range(0, 99) < take_idle_pct) begin
			res_ch.ready <= 1'b0;
			take_gap <= $urandom_range(0, 2);
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	task automatic queue_word(input logic has, input logic [DIST_W-1:0] d,
			input logic [ID_W-1:0] id, input logic eoq);
		pending_words.push_back('{has, d, id, eoq});
		words_queued++;
	endtask

	// wait for the block to go quiet, then let its pipeline empty
	task automatic wait_quiet();
		while (words_taken != words_queued || expected_answers.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_k(input int v);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= knis_pkg::K_BITS'(v);
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		k_setting = v;
	endtask

	task automatic queue_query(input int len);
		bit bare_end;
		bare_end = (len == 0) || ($urandom_range(0, 5) == 0);
		for (int i = 0; i < len; i++) begin
			// noise words: no candidate, no end
			if ($urandom_range(0, 7) == 0)
				queue_word(1'b0, $urandom(), ID_W'($urandom()), 1'b0);
			queue_word(1'b1, pick_distance(), ID_W'($urandom_range(0, 16'hFFFF)),
				!bare_end && (i == len - 1));
			random_items++;
		end
		if (bare_end) begin
			queue_word(1'b0, $urandom(), ID_W'($urandom()), 1'b1);
			random_items++;
		end
	endtask

	initial begin : stimulus
		int k_plan [7];
		int phase_start;
		bit first_query;

		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		cand_ch.valid = 1'b0;
		cand_ch.has_candidate = 1'b0;
		cand_ch.distance      = '0;
		cand_ch.candidate_id  = '0;
		cand_ch.end_of_query  = 1'b0;
		res_ch.ready  = 1'b0;
		held_count    = 0;
		k_setting     = knis_pkg::K_RESET;
		allow_idle    = 1'b1;
		send_idle_pct = 20;
		take_idle_pct = 20;
		send_gap = 0;
		take_gap = 0;
		words_queued = 0;
		words_taken = 0;
		answers_checked = 0;
		queries_closed = 0;
		random_items = 0;
		fail_count = 0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset k: empty query, then a noise word and a two-candidate query
		queue_word(1'b0, '0, '0, 1'b1);
		queue_word(1'b0, $urandom(), ID_W'($urandom()), 1'b0);
		queue_word(1'b1, 32'h8000_0000, 16'hA5A5, 1'b0);
		queue_word(1'b1, 32'h0000_0000, 16'h5A5A, 1'b1);
		wait_quiet();

		// k = 3: ties keep arrival order, strict replacement of the worst
		set_k(3);
		queue_word(1'b1, 32'd5, 16'h0001, 1'b0);
		queue_word(1'b1, 32'd5, 16'h0002, 1'b0);
		queue_word(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		queue_word(1'b1, 32'd5, 16'h0003, 1'b0);
		queue_word(1'b1, 32'd0, 16'h0000, 1'b0);
		queue_word(1'b1, 32'd5, 16'h1234, 1'b1);
		wait_quiet();

		// k = 0: candidates ignored, one invalid answer
		set_k(0);
		queue_word(1'b1, 32'd7, 16'h0007, 1'b0);
		queue_word(1'b1, 32'd9, 16'h0009, 1'b1);
		wait_quiet();

		// lower k between words of one query, then close with a bare marker
		set_k(8);
		for (int i = 0; i < 6; i++)
			queue_word(1'b1, $urandom_range(0, 20), ID_W'($urandom_range(0, 16'hFFFF)),
				1'b0);
		wait_quiet();
		set_k(2);
		queue_word(1'b0, '0, '0, 1'b1);
		wait_quiet();

		k_plan = '{16, 1, 31, $urandom_range(2, 15), 0, $urandom_range(17, 30), 16};
		for (int p = 0; p < 7; p++) begin
			wait_quiet();
			set_k(k_plan[p]);
			send_idle_pct = (p == 3) ? 0 : $urandom_range(10, 40);
			take_idle_pct = (p == 2) ? 0 : $urandom_range(10, 40);
			allow_idle = (p < 6);
			phase_start = random_items;
			first_query = 1'b1;
			while (random_items - phase_start < 10) begin
				// make sure large k settings see more candidates than they keep
				if ((first_query && k_plan[p] >= KEEP_MAX) || $urandom_range(0, 3) == 0)
					queue_query($urandom_range(17, 20));
				else
					queue_query($urandom_range(0, 6));
				first_query = 1'b0;
			end
		end

		wait_quiet();
		repeat (10) @(negedge clk);
		$display("checked %0d result words from %0d queries, %0d input words taken",
			answers_checked, queries_closed, words_taken);
		$display("k covered 0, 1, 2, 3, 8, 16, above 16 and a mid-query drop; idling on both sides");
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin : watchdog
		#(2_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: sim.f
rtl/knis_pkg.sv
rtl/knis_cand_if.sv
rtl/knis_res_if.sv
rtl/knis_cell.sv
rtl/k_nearest_insertion_select.sv
verif/tb_k_nearest_insertion_select.sv
